// ===== hdl/hex_line_frame_deframer_assert.svh =====
// assertion macros shared by the deframer rtl
// needs clk and arst_n in the scope of each use
`ifndef HEX_LINE_FRAME_DEFRAMER_ASSERT_SVH
`define HEX_LINE_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, off during reset
`define HLFD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define HLFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/hlfd_pkg.sv =====
// types, constants and per-character decode functions of the hex line deframer
// no dependencies
package hlfd_pkg;

	localparam int unsigned ChunkChars = 42;
	localparam int unsigned TsChars    = 16;
	localparam int unsigned IdChars    = 24;
	localparam int unsigned DataChars  = 40;
	localparam int unsigned CntW       = 6;

	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TAB   = 8'd9;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_HEX    = 2'd1;
	localparam logic [1:0] ST_SHORT_LINE = 2'd2;
	localparam logic [1:0] ST_UNUSED     = 2'd3;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] timestamp_bits;
		logic [31:0] frame_id;
		logic [63:0] data_word;
	} res_t;

	typedef struct packed {
		logic [63:0]     ts_accum;
		logic [31:0]     id_accum;
		logic [63:0]     data_accum;
		logic [CntW-1:0] chunk_char_count;
		logic            chunk_bad_flag;
		logic            line_has_chunk;
		logic            pending_cr;
	} state_t;

	typedef struct packed {
		state_t st;
		logic   emit;
		res_t   res;
	} step_t;

	// hex digit value, bit 4 set for a non-hex character
	function automatic logic [4:0] hex_value(logic [7:0] c);
		logic [4:0] v;
		begin
			if (c >= "0" && c <= "9") v = 5'(c - "0");
			else if (c >= "a" && c <= "f") v = 5'(c - "a" + 8'd10);
			else if (c >= "A" && c <= "F") v = 5'(c - "A" + 8'd10);
			else v = 5'd16;
			return v;
		end
	endfunction

	// one line character into the current chunk
	function automatic step_t take_char(state_t st_in, logic [7:0] c);
		step_t           o;
		logic [4:0]      v;
		logic [3:0]      nib;
		logic [CntW-1:0] pos;
		logic [CntW-1:0] cnt_nxt;
		begin
			o.st   = st_in;
			o.emit = 1'b0;
			o.res  = '0;
			if (c != CH_SPACE && c != CH_TAB) begin
				v   = hex_value(c);
				nib = v[3:0];
				if (v[4]) begin
					o.st.chunk_bad_flag = 1'b1;
					nib = 4'd0;
				end
				pos = st_in.chunk_char_count;
				if (pos < CntW'(TsChars))
					o.st.ts_accum = {st_in.ts_accum[59:0], nib};
				else if (pos < CntW'(IdChars))
					o.st.id_accum = {st_in.id_accum[27:0], nib};
				else if (pos < CntW'(DataChars))
					o.st.data_accum = {st_in.data_accum[59:0], nib};
				cnt_nxt = pos + CntW'(1);
				o.st.chunk_char_count = cnt_nxt;
				if (cnt_nxt >= CntW'(ChunkChars)) begin
					o.emit = 1'b1;
					if (o.st.chunk_bad_flag) begin
						o.res.status = ST_BAD_HEX;
					end else begin
						o.res.status         = ST_OK;
						o.res.timestamp_bits = o.st.ts_accum;
						o.res.frame_id       = o.st.id_accum;
						o.res.data_word      = o.st.data_accum;
					end
					o.st.line_has_chunk   = 1'b1;
					o.st.ts_accum         = '0;
					o.st.id_accum         = '0;
					o.st.data_accum       = '0;
					o.st.chunk_char_count = '0;
					o.st.chunk_bad_flag   = 1'b0;
				end
			end
			return o;
		end
	endfunction

	// full per-item update: pending cr, then the character itself
	function automatic step_t char_step(state_t st_in, logic [7:0] c);
		step_t o;
		step_t a;
		step_t b;
		logic  done;
		begin
			o.st   = st_in;
			o.emit = 1'b0;
			o.res  = '0;
			done   = 1'b0;
			if (st_in.pending_cr) begin
				o.st.pending_cr = 1'b0;
				if (c == CH_LF) begin
					// line end
					if (!st_in.line_has_chunk) begin
						o.emit       = 1'b1;
						o.res.status = ST_SHORT_LINE;
					end
					o.st.ts_accum         = '0;
					o.st.id_accum         = '0;
					o.st.data_accum       = '0;
					o.st.chunk_char_count = '0;
					o.st.chunk_bad_flag   = 1'b0;
					o.st.line_has_chunk   = 1'b0;
					done = 1'b1;
				end else begin
					// lone cr counts as a line character
					a = take_char(o.st, CH_CR);
					o = a;
				end
			end
			if (!done) begin
				if (c == CH_CR) begin
					o.st.pending_cr = 1'b1;
				end else begin
					b = take_char(o.st, c);
					o.st = b.st;
					if (!o.emit) begin
						o.emit = b.emit;
						o.res  = b.res;
					end
				end
			end
			return o;
		end
	endfunction

endpackage

// ===== hdl/hlfd_char_if.sv =====
// input channel: one received character per item
// depends on nothing
interface hlfd_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink (input valid, input char_in, output ready);
endinterface

// ===== hdl/hlfd_result_if.sv =====
// output channel: one decoded frame or line status per item
// depends on nothing
interface hlfd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] timestamp_bits;
	logic [31:0] frame_id;
	logic [63:0] data_word;

	modport source (output valid, output status, output timestamp_bits,
		output frame_id, output data_word, input ready);
	modport sink (input valid, input status, input timestamp_bits,
		input frame_id, input data_word, output ready);
endinterface

// ===== hdl/hex_line_frame_deframer.sv =====
// Hex line deframer: takes one received character per item and gives one result per
// completed 42-character hex chunk (ok or bad_hex) and per line that ends with CR LF
// before a chunk completes (short_line). One character is accepted every cycle; a
// character goes into an input register, is decoded by the single-pass chunk logic
// from there and its result, if any, is loaded into the result register. Input stalls
// only while the result register holds an item that the sink has not taken.
// depends on hlfd_pkg, hlfd_char_if, hlfd_result_if, hlfd_chunk_dec and the assert header
`include "hex_line_frame_deframer_assert.svh"

module hex_line_frame_deframer
	import hlfd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	hlfd_char_if.sink    char_chan,
	hlfd_result_if.source result_chan
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       out_valid_q;
	res_t       out_q;
	logic       out_free;
	logic       step_go;
	logic       emit;
	res_t       res;

	assign out_free        = !out_valid_q || result_chan.ready;
	assign step_go         = valid_s1 && out_free;
	assign char_chan.ready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_chan.ready) begin
			valid_s1 <= char_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_chan.ready && char_chan.valid) begin
			char_s1 <= char_chan.char_in;
		end
	end

	hlfd_chunk_dec u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_go),
		.char_s1 (char_s1),
		.emit    (emit),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_go && emit) begin
			out_valid_q <= 1'b1;
		end else if (result_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && emit) begin
			out_q <= res;
		end
	end

	assign result_chan.valid          = out_valid_q;
	assign result_chan.status         = out_q.status;
	assign result_chan.timestamp_bits = out_q.timestamp_bits;
	assign result_chan.frame_id       = out_q.frame_id;
	assign result_chan.data_word      = out_q.data_word;

	`HLFD_ASSERT_SAME(a_no_unused_status, out_valid_q, out_q.status != ST_UNUSED,
		"unused status code")
	`HLFD_ASSERT_SAME(a_zero_payload, out_valid_q && out_q.status != ST_OK,
		out_q.timestamp_bits == '0 && out_q.frame_id == '0 && out_q.data_word == '0,
		"nonzero payload on error status")
	`HLFD_ASSERT_SAME(a_stall_cause, !char_chan.ready,
		valid_s1 && out_valid_q && !result_chan.ready, "input stalled without cause")
	`HLFD_ASSERT_NEXT(a_emit_loads, step_go && emit, out_valid_q, "result lost")

endmodule

// ===== hdl/hlfd_chunk_dec.sv =====
// chunk decoder: line and chunk state registers plus the per-character update
// depends on hlfd_pkg and hex_line_frame_deframer_assert.svh
`include "hex_line_frame_deframer_assert.svh"

module hlfd_chunk_dec
	import hlfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [7:0] char_s1,
	output logic       emit,
	output res_t       res
);

	state_t state_q;
	step_t  nxt;

	// combinational update of one character
	always_comb begin
		nxt = char_step(state_q, char_s1);
	end

	assign emit = step_en & nxt.emit;
	assign res  = nxt.res;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step_en) begin
			state_q <= nxt.st;
		end
	end

	`HLFD_ASSERT_SAME(a_cnt_range, 1'b1, state_q.chunk_char_count < CntW'(ChunkChars), "chunk count out of range")
	`HLFD_ASSERT_SAME(a_short_only_at_lf, emit && res.status == ST_SHORT_LINE, state_q.pending_cr && char_s1 == CH_LF, "short line outside cr lf")

endmodule
